[hdl/tsbm_pkg.sv]
// Package for the two-wire sensor bus master: sequencer phase codes,
// operation codes, configuration defaults and the beat structs.
// No dependencies; used by tsbm_seq and two_wire_sensor_bus_master.
package tsbm_pkg;

   // Bus timing constants
   localparam int unsigned RESET_CLOCK_COUNT = 9;   // clocks before a soft reset, 9..15
   localparam int unsigned WIDE_PULSE_TICKS  = 3;   // ticks of a wide clock level, 1..3

   // Field widths
   localparam int unsigned PHASE_W = 5;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned TMO_W   = 20;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned BIT_W   = 4;
   localparam int unsigned HOLD_W  = 2;
   localparam int unsigned CSR_W   = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TEMP     = 3'd0;
   localparam logic [OP_W-1:0] OP_HUMID    = 3'd1;
   localparam logic [OP_W-1:0] OP_STAT_RD  = 3'd2;
   localparam logic [OP_W-1:0] OP_STAT_WR  = 3'd3;
   localparam logic [OP_W-1:0] OP_SOFT_RST = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_W-1:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_TEMP_CMD   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_HUMID_CMD  = 3'd2;
   localparam logic [CSR_W-1:0] CSR_STAT_RD    = 3'd3;
   localparam logic [CSR_W-1:0] CSR_STAT_WR    = 3'd4;
   localparam logic [CSR_W-1:0] CSR_SOFT_RST   = 3'd5;

   // Configuration reset values
   localparam logic [TMO_W-1:0]  TIMEOUT_RESET    = 20'd100000;
   localparam logic [BYTE_W-1:0] TEMP_CMD_RESET   = 8'd3;
   localparam logic [BYTE_W-1:0] HUMID_CMD_RESET  = 8'd5;
   localparam logic [BYTE_W-1:0] STAT_RD_RESET    = 8'd7;
   localparam logic [BYTE_W-1:0] STAT_WR_RESET    = 8'd6;
   localparam logic [BYTE_W-1:0] SOFT_RST_RESET   = 8'd30;

   // Byte countdown markers held in the outgoing byte during reads, the status-write sent flag and the error limit
   localparam logic [BYTE_W-1:0] RD_TWO_BYTES   = 8'd3;
   localparam logic [BYTE_W-1:0] RD_ONE_BYTE    = 8'd2;
   localparam logic [BYTE_W-1:0] RD_DATA_MIN    = 8'd2;
   localparam logic [VALUE_W-1:0] STAT_WR_SENT  = 16'h0100;
   localparam logic [ERR_W-1:0]  ERR_MAX        = 2'd3;

   // Sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
   localparam logic [PHASE_W-1:0] PH_RS_HIGH  = 5'd1;
   localparam logic [PHASE_W-1:0] PH_RS_LOW   = 5'd2;
   localparam logic [PHASE_W-1:0] PH_ST0      = 5'd3;
   localparam logic [PHASE_W-1:0] PH_ST1      = 5'd4;
   localparam logic [PHASE_W-1:0] PH_ST2      = 5'd5;
   localparam logic [PHASE_W-1:0] PH_ST3      = 5'd6;
   localparam logic [PHASE_W-1:0] PH_ST4      = 5'd7;
   localparam logic [PHASE_W-1:0] PH_ST5      = 5'd8;
   localparam logic [PHASE_W-1:0] PH_WB_SETUP = 5'd9;
   localparam logic [PHASE_W-1:0] PH_WB_HIGH  = 5'd10;
   localparam logic [PHASE_W-1:0] PH_WB_LOW   = 5'd11;
   localparam logic [PHASE_W-1:0] PH_WA_SETUP = 5'd12;
   localparam logic [PHASE_W-1:0] PH_WA_HIGH  = 5'd13;
   localparam logic [PHASE_W-1:0] PH_WA_END   = 5'd14;
   localparam logic [PHASE_W-1:0] PH_WAIT     = 5'd15;
   localparam logic [PHASE_W-1:0] PH_RB_HIGH  = 5'd16;
   localparam logic [PHASE_W-1:0] PH_RB_LOW   = 5'd17;
   localparam logic [PHASE_W-1:0] PH_RA_SETUP = 5'd18;
   localparam logic [PHASE_W-1:0] PH_RA_HIGH  = 5'd19;
   localparam logic [PHASE_W-1:0] PH_RA_HOLD  = 5'd20;

   typedef struct packed {
      logic [TMO_W-1:0]  timeout_limit;
      logic [BYTE_W-1:0] temperature_command;
      logic [BYTE_W-1:0] humidity_command;
      logic [BYTE_W-1:0] status_read_command;
      logic [BYTE_W-1:0] status_write_command;
      logic [BYTE_W-1:0] soft_reset_command;
   } cfg_type;

   typedef struct packed {
      logic              start_request;
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] status_write_value;
      logic              data_pin;
   } tick_type;

   typedef struct packed {
      logic               clock_level;
      logic               data_drive_enable;
      logic               data_drive_level;
      logic               busy;
      logic               done;
      logic [VALUE_W-1:0] result_value;
      logic [BYTE_W-1:0]  result_checksum;
      logic [ERR_W-1:0]   error_count;
   } result_type;

endpackage

[hdl/two_wire_sensor_bus_master.sv]
// Data path: a tick beat enters an input register, and the sequencer steps on it once the
// result register is free; the result beat is registered at that same step.
// Throughput: one tick per cycle while rsp_ready holds; the input register and the result register decouple
// the two sides, the limit being the single sequencer state update per tick.
// Reset: synchronous; sequencer idles with all fields zero, configuration takes defaults.
// Top level of the two-wire sensor bus master. Depends on tsbm_pkg and tsbm_seq.
module two_wire_sensor_bus_master (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_start_request,
   input  logic [2:0]                    req_operation,
   input  logic [7:0]                    req_status_write_value,
   input  logic                          req_data_pin,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_clock_level,
   output logic                          rsp_data_drive_enable,
   output logic                          rsp_data_drive_level,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [15:0]                   rsp_result_value,
   output logic [7:0]                    rsp_result_checksum,
   output logic [1:0]                    rsp_error_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tsbm_pkg::CSR_W-1:0]    csr_index,
   input  logic [tsbm_pkg::TMO_W-1:0]    csr_wdata
);
   import tsbm_pkg::*;

   cfg_type    cfg_ff;
   tick_type   tick_ff;
   logic       in_valid_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   result_type seq_result;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit        <= TIMEOUT_RESET;
         cfg_ff.temperature_command  <= TEMP_CMD_RESET;
         cfg_ff.humidity_command     <= HUMID_CMD_RESET;
         cfg_ff.status_read_command  <= STAT_RD_RESET;
         cfg_ff.status_write_command <= STAT_WR_RESET;
         cfg_ff.soft_reset_command   <= SOFT_RST_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT:   cfg_ff.timeout_limit        <= csr_wdata;
            CSR_TEMP_CMD:  cfg_ff.temperature_command  <= csr_wdata[BYTE_W-1:0];
            CSR_HUMID_CMD: cfg_ff.humidity_command     <= csr_wdata[BYTE_W-1:0];
            CSR_STAT_RD:   cfg_ff.status_read_command  <= csr_wdata[BYTE_W-1:0];
            CSR_STAT_WR:   cfg_ff.status_write_command <= csr_wdata[BYTE_W-1:0];
            CSR_SOFT_RST:  cfg_ff.soft_reset_command   <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: take a tick beat whenever the slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_ff.start_request      <= req_start_request;
         tick_ff.operation          <= req_operation;
         tick_ff.status_write_value <= req_status_write_value;
         tick_ff.data_pin           <= req_data_pin;
      end
   end

   tsbm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .tick    (tick_ff),
      .cfg     (cfg_ff),
      .result  (seq_result)
   );

   // Result register: load on a step, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_clock_level       = rsp_ff.clock_level;
   assign rsp_data_drive_enable = rsp_ff.data_drive_enable;
   assign rsp_data_drive_level  = rsp_ff.data_drive_level;
   assign rsp_busy_res          = rsp_ff.busy;
   assign rsp_done_res          = rsp_ff.done;
   assign rsp_result_value      = rsp_ff.result_value;
   assign rsp_result_checksum   = rsp_ff.result_checksum;
   assign rsp_error_count       = rsp_ff.error_count;

   // A waiting tick is never overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(tick_ff)))
      else $error("pending tick lost");

   // A result beat only appears from a tick in the input register
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result beat without a tick");

   // A finished transaction never reports busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && seq_result.done) |-> !seq_result.busy)
      else $error("done while busy");

endmodule

[hdl/tsbm_seq.sv]
// Bus sequencer: holds the transaction state and advances it by at most one phase per tick.
// Produces the bus levels and status for the tick it consumes.
// Depends on tsbm_pkg.
module tsbm_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  tsbm_pkg::tick_type   tick,
   input  tsbm_pkg::cfg_type    cfg,
   output tsbm_pkg::result_type result
);
   import tsbm_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [OP_W-1:0]    cur_op_ff, cur_op_in;
   logic [BIT_W-1:0]   bit_pos_ff, bit_pos_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [TMO_W-1:0]   wait_cnt_ff, wait_cnt_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [BYTE_W-1:0]  checksum_ff, checksum_in;
   logic [ERR_W-1:0]   errors_ff, errors_in;
   logic               done;

   logic [BIT_W-1:0]   bit_pos_inc;
   logic [HOLD_W:0]    hold_inc;
   logic               wide_over;
   logic [TMO_W-1:0]   wait_inc;
   logic [ERR_W-1:0]   errors_sat;
   logic [BYTE_W-1:0]  command;
   logic               clk_lvl, drv_en, drv_lvl;

   // Shared step helpers
   assign bit_pos_inc = bit_pos_ff + 1'b1;
   assign hold_inc    = {1'b0, hold_ff} + 1'b1;
   assign wide_over   = (hold_inc >= (HOLD_W+1)'(WIDE_PULSE_TICKS));
   assign wait_inc    = wait_cnt_ff + 1'b1;
   assign errors_sat  = (errors_ff < ERR_MAX) ? errors_ff + 1'b1 : errors_ff;

   // Pick the command byte for the running operation
   always_comb begin
      case (cur_op_ff)
         OP_TEMP:    command = cfg.temperature_command;
         OP_HUMID:   command = cfg.humidity_command;
         OP_STAT_RD: command = cfg.status_read_command;
         OP_STAT_WR: command = cfg.status_write_command;
         default:    command = cfg.soft_reset_command;
      endcase
   end

   // Advance one phase
   always_comb begin
      phase_in    = phase_ff;
      cur_op_in   = cur_op_ff;
      bit_pos_in  = bit_pos_ff;
      hold_in     = hold_ff;
      wait_cnt_in = wait_cnt_ff;
      shift_in    = shift_ff;
      out_byte_in = out_byte_ff;
      value_in    = value_ff;
      checksum_in = checksum_ff;
      errors_in   = errors_ff;
      done        = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (tick.start_request && tick.operation <= OP_SOFT_RST) begin
               cur_op_in   = tick.operation;
               errors_in   = '0;
               value_in    = (tick.operation == OP_STAT_WR) ?
                             {{(VALUE_W-BYTE_W){1'b0}}, tick.status_write_value} : '0;
               checksum_in = '0;
               bit_pos_in  = '0;
               hold_in     = '0;
               wait_cnt_in = '0;
               shift_in    = '0;
               out_byte_in = '0;
               phase_in    = (tick.operation == OP_SOFT_RST) ? PH_RS_HIGH : PH_ST0;
            end
         end
         PH_RS_HIGH: phase_in = PH_RS_LOW;
         PH_RS_LOW: begin
            if (bit_pos_inc >= BIT_W'(RESET_CLOCK_COUNT) || bit_pos_inc == '0) begin
               bit_pos_in = '0;
               phase_in   = PH_ST0;
            end else begin
               bit_pos_in = bit_pos_inc;
               phase_in   = PH_RS_HIGH;
            end
         end
         PH_ST0: phase_in = PH_ST1;
         PH_ST1: phase_in = PH_ST2;
         PH_ST2: begin
            phase_in = PH_ST3;
            hold_in  = '0;
         end
         PH_ST3: begin
            hold_in = wide_over ? '0 : hold_inc[HOLD_W-1:0];
            if (wide_over) phase_in = PH_ST4;
         end
         PH_ST4: phase_in = PH_ST5;
         PH_ST5: begin
            out_byte_in = command;
            bit_pos_in  = '0;
            phase_in    = PH_WB_SETUP;
         end
         PH_WB_SETUP: begin
            phase_in = PH_WB_HIGH;
            hold_in  = '0;
         end
         PH_WB_HIGH: begin
            hold_in = wide_over ? '0 : hold_inc[HOLD_W-1:0];
            if (wide_over) phase_in = PH_WB_LOW;
         end
         PH_WB_LOW: begin
            if (bit_pos_inc >= BIT_W'(BYTE_W)) begin
               bit_pos_in = '0;
               phase_in   = PH_WA_SETUP;
            end else begin
               bit_pos_in = bit_pos_inc;
               phase_in   = PH_WB_SETUP;
            end
         end
         PH_WA_SETUP: phase_in = PH_WA_HIGH;
         PH_WA_HIGH: begin
            if (tick.data_pin) errors_in = errors_sat;
            phase_in = PH_WA_END;
         end
         PH_WA_END: begin
            if (cur_op_ff <= OP_HUMID) begin
               wait_cnt_in = '0;
               phase_in    = PH_WAIT;
            end else if (cur_op_ff == OP_STAT_RD) begin
               out_byte_in = RD_ONE_BYTE;
               bit_pos_in  = '0;
               shift_in    = '0;
               phase_in    = PH_RB_HIGH;
            end else if (cur_op_ff == OP_STAT_WR && (value_ff & STAT_WR_SENT) == '0) begin
               // Send the status byte after the command
               out_byte_in = value_ff[BYTE_W-1:0];
               value_in    = value_ff | STAT_WR_SENT;
               bit_pos_in  = '0;
               phase_in    = PH_WB_SETUP;
            end else begin
               value_in = {{(VALUE_W-BYTE_W){1'b0}}, value_ff[BYTE_W-1:0]};
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         PH_WAIT: begin
            // Wait for the sensor to pull data low, or time out and read anyway
            if (!tick.data_pin) begin
               out_byte_in = RD_TWO_BYTES;
               bit_pos_in  = '0;
               shift_in    = '0;
               phase_in    = PH_RB_HIGH;
            end else begin
               wait_cnt_in = wait_inc;
               if (wait_inc >= cfg.timeout_limit || wait_inc == '0) begin
                  errors_in   = errors_sat;
                  out_byte_in = RD_TWO_BYTES;
                  bit_pos_in  = '0;
                  shift_in    = '0;
                  phase_in    = PH_RB_HIGH;
               end
            end
         end
         PH_RB_HIGH: begin
            shift_in = {shift_ff[BYTE_W-2:0], tick.data_pin};
            phase_in = PH_RB_LOW;
         end
         PH_RB_LOW: begin
            if (bit_pos_inc >= BIT_W'(BYTE_W)) begin
               bit_pos_in = '0;
               if (out_byte_ff >= RD_DATA_MIN) begin
                  value_in = {value_ff[BYTE_W-1:0], shift_ff};
               end else begin
                  checksum_in = shift_ff;
               end
               phase_in = PH_RA_SETUP;
            end else begin
               bit_pos_in = bit_pos_inc;
               phase_in   = PH_RB_HIGH;
            end
         end
         PH_RA_SETUP: begin
            phase_in = PH_RA_HIGH;
            hold_in  = '0;
         end
         PH_RA_HIGH: begin
            hold_in = wide_over ? '0 : hold_inc[HOLD_W-1:0];
            if (wide_over) phase_in = PH_RA_HOLD;
         end
         PH_RA_HOLD: begin
            if (out_byte_ff >= RD_DATA_MIN) begin
               out_byte_in = out_byte_ff - 1'b1;
               bit_pos_in  = '0;
               shift_in    = '0;
               phase_in    = PH_RB_HIGH;
            end else begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Drive the bus levels for the phase just entered
   always_comb begin
      clk_lvl = 1'b0;
      drv_en  = 1'b0;
      drv_lvl = 1'b0;
      case (phase_in)
         PH_RS_HIGH, PH_ST1, PH_ST5: begin
            clk_lvl = 1'b1;
            drv_en  = 1'b1;
            drv_lvl = 1'b1;
         end
         PH_RS_LOW, PH_ST0, PH_WA_SETUP: begin
            drv_en  = 1'b1;
            drv_lvl = 1'b1;
         end
         PH_ST2, PH_ST4: begin
            clk_lvl = 1'b1;
            drv_en  = 1'b1;
         end
         PH_ST3: drv_en = 1'b1;
         PH_WB_SETUP, PH_WB_HIGH, PH_WB_LOW: begin
            clk_lvl = (phase_in == PH_WB_HIGH);
            drv_en  = 1'b1;
            drv_lvl = out_byte_in[~bit_pos_in[2:0]];
         end
         PH_WA_HIGH, PH_RB_HIGH: clk_lvl = 1'b1;
         PH_RA_SETUP, PH_RA_HIGH, PH_RA_HOLD: begin
            clk_lvl = (phase_in == PH_RA_HIGH);
            drv_en  = 1'b1;
            drv_lvl = (out_byte_in < RD_DATA_MIN);
         end
         default: ;
      endcase
   end

   assign result.clock_level       = clk_lvl;
   assign result.data_drive_enable = drv_en;
   assign result.data_drive_level  = drv_lvl;
   assign result.busy              = (phase_in != PH_IDLE);
   assign result.done              = done;
   assign result.result_value      = value_in;
   assign result.result_checksum   = checksum_in;
   assign result.error_count       = errors_in;

   // Hold state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cur_op_ff   <= '0;
         bit_pos_ff  <= '0;
         hold_ff     <= '0;
         wait_cnt_ff <= '0;
         shift_ff    <= '0;
         out_byte_ff <= '0;
         value_ff    <= '0;
         checksum_ff <= '0;
         errors_ff   <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         cur_op_ff   <= cur_op_in;
         bit_pos_ff  <= bit_pos_in;
         hold_ff     <= hold_in;
         wait_cnt_ff <= wait_cnt_in;
         shift_ff    <= shift_in;
         out_byte_ff <= out_byte_in;
         value_ff    <= value_in;
         checksum_ff <= checksum_in;
         errors_ff   <= errors_in;
      end
   end

   // Wide-pulse counter never reaches the pulse length
   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hold_ff < HOLD_W'(WIDE_PULSE_TICKS))
      else $error("wide pulse counter out of range");

   // Bit counter stays below the reset clock count
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff < BIT_W'(RESET_CLOCK_COUNT))
      else $error("bit position out of range");

   // Errors only grow during a transaction
   a_err_grow: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff != PH_IDLE) |=> errors_ff >= $past(errors_ff))
      else $error("error count dropped mid-transaction");

endmodule
